// ===== rtl/cmwc_pkg.sv =====
// shared types and constants of the cmwc generator
package cmwc_pkg;

  localparam int unsigned LAG_DEPTH_DEF = 4096;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CARRY_W = 30;

  localparam logic [WORD_W-1:0] LCG_MUL     = 32'd1664525;
  localparam logic [WORD_W-1:0] LCG_INC     = 32'd1013904223;
  localparam logic [WORD_W-1:0] CARRY_SCALE = 32'd809430660;
  localparam logic [WORD_W-1:0] CMWC_MUL    = 32'd18782;
  localparam logic [WORD_W-1:0] CMWC_BASE   = 32'hffff_fffe;

  typedef enum logic {
    ACT_SEED = 1'b0,
    ACT_DRAW = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_SCALE,
    ST_CARRY,
    ST_READ,
    ST_FIX
  } state_e;

  // operands of the shared multiply-add unit: res = a * b + c
  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
  } mac_op_t;

endpackage

// ===== rtl/cmwc_in_if.sv =====
// input channel: action and seed word
interface cmwc_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] seed_value;

  modport source (output valid, output action, output seed_value, input ready);
  modport sink (input valid, input action, input seed_value, output ready);
endinterface

// ===== rtl/cmwc_out_if.sv =====
// output channel: random word
interface cmwc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink (input valid, input random_value, output ready);
endinterface

// ===== rtl/cmwc_random_generator_unit.sv =====
// top level of the lag-4096 complementary multiply-with-carry generator
//
// During a seed item the shared multiply-add unit runs the linear congruential
// sequence once per cycle, writing one lag-store entry per cycle, then one more
// step and a scaling multiply give the initial carry. A draw item runs through
// its steps in order (store read, multiply-add, carry correction and
// write-back) and gives one word on the output channel; input ready is low
// during that work. The output word sits in a register, so the next item is
// taken while it waits; a draw whose word is done waits only if the previous
// word is still not taken. Draws before the first seed read unwritten entries.
module cmwc_random_generator_unit #(
  parameter int unsigned LAG_DEPTH = cmwc_pkg::LAG_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cmwc_in_if.sink     in_i,
  cmwc_out_if.source  out_o
);

  localparam int unsigned AW = $clog2(LAG_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam logic [AW-1:0] POS_LAST = AW'(LAG_DEPTH - 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(LAG_DEPTH);

  cmwc_pkg::state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [cmwc_pkg::CARRY_W-1:0] carry_q, carry_d;
  logic [cmwc_pkg::WORD_W-1:0] seed_q, seed_d;
  logic out_valid_q, out_valid_d;
  logic [cmwc_pkg::WORD_W-1:0] out_data_q, out_data_d;

  logic in_acc;
  logic out_free;
  logic [AW-1:0] pos_next;
  logic [CW-1:0] cnt_m1;

  cmwc_pkg::mac_op_t mac_op;
  logic mac_en;
  logic [63:0] prod;

  logic mem_we;
  logic [AW-1:0] mem_waddr;
  logic [cmwc_pkg::WORD_W-1:0] mem_wdata;
  logic mem_re;
  logic [AW-1:0] mem_raddr;
  logic [cmwc_pkg::WORD_W-1:0] mem_rdata;

  // carry correction
  logic [cmwc_pkg::WORD_W-1:0] fix_hi, fix_x0, fix_x, fix_c, fix_word;
  logic fix_wrap;

  cmwc_mac u_mac (
    .clk_i (clk_i),
    .en_i  (mac_en),
    .op_i  (mac_op),
    .res_o (prod)
  );

  cmwc_lag_mem #(
    .DEPTH (LAG_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_i.ready         = (state_q == cmwc_pkg::ST_IDLE);
  assign in_acc             = in_i.valid && in_i.ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.random_value = out_data_q;
  assign out_free           = !out_valid_q || out_o.ready;

  assign pos_next = (pos_q == POS_LAST) ? '0 : pos_q + AW'(1);
  assign cnt_m1   = cnt_q - CW'(1);

  always_comb begin
    fix_hi   = prod[63:32];
    fix_x0   = prod[31:0] + fix_hi;
    fix_wrap = (fix_x0 < fix_hi);
    fix_x    = fix_wrap ? fix_x0 + 32'd1 : fix_x0;
    fix_c    = fix_wrap ? fix_hi + 32'd1 : fix_hi;
    fix_word = cmwc_pkg::CMWC_BASE - fix_x;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    carry_d     = carry_q;
    seed_d      = seed_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mac_en      = 1'b0;
    mac_op      = '0;
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = fix_word;
    mem_re      = 1'b0;
    mem_raddr   = pos_next;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      cmwc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_i.action == cmwc_pkg::ACT_DRAW) begin
            mem_re  = 1'b1;
            pos_d   = pos_next;
            state_d = cmwc_pkg::ST_READ;
          end else begin
            seed_d  = in_i.seed_value;
            cnt_d   = '0;
            state_d = cmwc_pkg::ST_SEED;
          end
        end
      end
      cmwc_pkg::ST_SEED: begin
        // one lcg step per cycle; the previous step's word lands in the store
        mac_en   = 1'b1;
        mac_op.a = (cnt_q == '0) ? seed_q : prod[31:0];
        mac_op.b = cmwc_pkg::LCG_MUL;
        mac_op.c = cmwc_pkg::LCG_INC;
        if (cnt_q != '0) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_m1[AW-1:0];
          mem_wdata = prod[31:0];
        end
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CNT_LAST) begin
          state_d = cmwc_pkg::ST_SCALE;
        end
      end
      cmwc_pkg::ST_SCALE: begin
        mac_en   = 1'b1;
        mac_op.a = prod[31:0];
        mac_op.b = cmwc_pkg::CARRY_SCALE;
        mac_op.c = '0;
        state_d  = cmwc_pkg::ST_CARRY;
      end
      cmwc_pkg::ST_CARRY: begin
        carry_d = prod[32 +: cmwc_pkg::CARRY_W];
        pos_d   = POS_LAST;
        state_d = cmwc_pkg::ST_IDLE;
      end
      cmwc_pkg::ST_READ: begin
        mac_en   = 1'b1;
        mac_op.a = mem_rdata;
        mac_op.b = cmwc_pkg::CMWC_MUL;
        mac_op.c = {{(cmwc_pkg::WORD_W - cmwc_pkg::CARRY_W){1'b0}}, carry_q};
        state_d  = cmwc_pkg::ST_FIX;
      end
      cmwc_pkg::ST_FIX: begin
        // hold here until the output register is free
        if (out_free) begin
          mem_we      = 1'b1;
          mem_waddr   = pos_q;
          mem_wdata   = fix_word;
          carry_d     = fix_c[cmwc_pkg::CARRY_W-1:0];
          out_valid_d = 1'b1;
          out_data_d  = fix_word;
          state_d     = cmwc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cmwc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cmwc_pkg::ST_IDLE;
      cnt_q       <= '0;
      pos_q       <= POS_LAST;
      carry_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      carry_q     <= carry_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seed_q     <= seed_d;
    out_data_q <= out_data_d;
  end

endmodule

// ===== rtl/cmwc_mac.sv =====
// shared 32x32 multiply-add unit with registered 64-bit result
module cmwc_mac (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  cmwc_pkg::mac_op_t     op_i,
  output logic [63:0]           res_o
);

  logic [63:0] res_d;
  logic [63:0] res_q;

  always_comb begin
    res_d = (64'(op_i.a) * 64'(op_i.b)) + 64'(op_i.c);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/cmwc_lag_mem.sv =====
// lag store: one write port, one read port with registered data
module cmwc_lag_mem #(
  parameter int unsigned DEPTH = cmwc_pkg::LAG_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [cmwc_pkg::WORD_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [cmwc_pkg::WORD_W-1:0] rdata_o
);

  logic [cmwc_pkg::WORD_W-1:0] mem_q [DEPTH];
  logic [cmwc_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cmwc_checker.sv =====
// port-level checks of the cmwc generator, bound to the top level
module cmwc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_action_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_data_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // input ready is low in the cycle after every accepted item
  a_busy_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("input ready right after an accepted item");

  // a seed never produces a word
  a_seed_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_action_i == cmwc_pkg::ACT_SEED && !out_valid_i) |=> !out_valid_i)
    else $error("word appeared after a seed item");

  // a new word only comes out of draw work, never from the idle state
  a_word_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("word appeared while the block was idle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_data_i)))
    else $error("stalled output word changed or dropped");

endmodule

bind cmwc_random_generator_unit cmwc_checker u_cmwc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_action_i (in_i.action),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.random_value)
);

// ===== test/testbench.sv =====
// self-checking testbench for the lag-4096 complementary multiply-with-carry generator
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_DEPTH = 4096;
  localparam logic [31:0] SEQ_MUL     = 32'd1664525;
  localparam logic [31:0] SEQ_INC     = 32'd1013904223;
  localparam logic [31:0] CARRY_MUL   = 32'd809430660;
  localparam logic [31:0] LAG_MUL     = 32'd18782;
  localparam logic [31:0] WORD_TOP    = 32'hffff_fffe;
  localparam int unsigned IDLE_LIMIT  = 40000;
  localparam int unsigned RANDOM_ITEMS = 1800;

  logic clk_i;
  logic rst_ni;

  cmwc_in_if  in_if ();
  cmwc_out_if out_if ();

  cmwc_random_generator_unit #(.LAG_DEPTH(STORE_DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // predictor state
  logic [31:0] lag_words [STORE_DEPTH];
  logic [29:0] carry_q;
  logic [11:0] slot_q;

  logic [31:0] pending_words [$];

  bit          tx_burst;
  bit          rx_burst;
  int unsigned rx_hold;
  int unsigned n_seeds;
  int unsigned n_draws;
  int unsigned n_checked;
  int unsigned n_mismatch;
  int unsigned n_wraps;
  int unsigned idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void fill_lag_words(input logic [31:0] seed);
    logic [31:0] s;
    logic [63:0] scaled;
    s = seed;
    for (int unsigned k = 0; k < STORE_DEPTH; k++) begin
      s = s * SEQ_MUL + SEQ_INC;
      lag_words[k] = s;
    end
    s = s * SEQ_MUL + SEQ_INC;
    scaled = {32'd0, s} * {32'd0, CARRY_MUL};
    carry_q = scaled[61:32];
    slot_q = 12'(STORE_DEPTH - 1);
  endfunction

  function automatic logic [31:0] next_cmwc_word();
    logic [63:0] t;
    logic [31:0] x;
    logic [31:0] c;
    logic [31:0] word;
    if (slot_q == 12'(STORE_DEPTH - 1)) begin
      slot_q = '0;
      n_wraps++;
    end else begin
      slot_q = slot_q + 12'd1;
    end
    t = {32'd0, LAG_MUL} * {32'd0, lag_words[slot_q]} + {34'd0, carry_q};
    c = t[63:32];
    x = t[31:0] + c;
    // carry correction when the low half wrapped
    if (x < c) begin
      x = x + 32'd1;
      c = c + 32'd1;
    end
    carry_q = c[29:0];
    word = WORD_TOP - x;
    lag_words[slot_q] = word;
    return word;
  endfunction

  task automatic send_item(input cmwc_pkg::action_e act, input logic [31:0] word);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.action     <= act;
    in_if.seed_value <= word;
    do @(posedge clk_i); while (!in_if.ready);
    if (act == cmwc_pkg::ACT_SEED) begin
      fill_lag_words(word);
      n_seeds++;
    end else begin
      pending_words.push_back(next_cmwc_word());
      n_draws++;
    end
  endtask

  // sender goes quiet until every expected word has come back
  task automatic drain_words();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic test_seed_extremes();
    logic [31:0] seeds [4];
    seeds = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000};
    // seed straight after seed, then draws with both extremes in the ignored word
    send_item(cmwc_pkg::ACT_SEED, 32'h1234_5678);
    foreach (seeds[i]) begin
      send_item(cmwc_pkg::ACT_SEED, seeds[i]);
      send_item(cmwc_pkg::ACT_DRAW, 32'h0000_0000);
      send_item(cmwc_pkg::ACT_DRAW, 32'hffff_ffff);
      send_item(cmwc_pkg::ACT_DRAW, $urandom());
      send_item(cmwc_pkg::ACT_DRAW, $urandom());
    end
    drain_words();
  endtask

  task automatic test_backpressure();
    rx_hold = 300;
    tx_burst = 1'b1;
    repeat (20) send_item(cmwc_pkg::ACT_DRAW, $urandom());
    tx_burst = 1'b0;
    drain_words();
  endtask

  task automatic test_random_traffic();
    send_item(cmwc_pkg::ACT_SEED, $urandom());
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 150 == 0) begin
        tx_burst = ($urandom_range(0, 2) == 0);
        rx_burst = ($urandom_range(0, 2) == 0);
      end
      if ($urandom_range(0, 99) < 3) send_item(cmwc_pkg::ACT_SEED, $urandom());
      else send_item(cmwc_pkg::ACT_DRAW, $urandom());
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    drain_words();
  endtask

  // receiver
  initial begin
    int unsigned gap;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold != 0) begin
        gap = rx_hold;
        rx_hold = 0;
      end else begin
        gap = rx_burst ? 0 : $urandom_range(0, 6);
      end
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
    end
  end

  // result checker
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_words.size() == 0) begin
        if (n_mismatch < 10)
          $display("unexpected word %08h with nothing pending", out_if.random_value);
        n_mismatch++;
      end else begin
        want = pending_words.pop_front();
        n_checked++;
        if (out_if.random_value !== want) begin
          if (n_mismatch < 10)
            $display("word mismatch: expected %08h got %08h", want, out_if.random_value);
          n_mismatch++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    idle_cycles = 0;
    rx_hold = 0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    n_seeds = 0;
    n_draws = 0;
    n_checked = 0;
    n_mismatch = 0;
    n_wraps = 0;
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.action <= cmwc_pkg::ACT_SEED;
    in_if.seed_value <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_seed_extremes();
    test_backpressure();
    test_random_traffic();

    // a seed may still be filling the store after the last word
    repeat (STORE_DEPTH + 16) @(posedge clk_i);
    if (pending_words.size() != 0) begin
      $display("%0d expected words never arrived", pending_words.size());
      n_mismatch++;
    end

    $display("covered %0d seeds and %0d draws, %0d words checked, %0d position wraps",
             n_seeds, n_draws, n_checked, n_wraps);
    $display("including seeds back to back, a long receiver stall and a drained sender pause");
    if (n_mismatch == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures", n_mismatch);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
